@@ src/d8fd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// D8 flow direction package
// Shared constants and types for the D8 drain direction pipeline.
// ----------------------------------------------------------------------------
package d8fd_pkg;

    // Configuration register indexes
    localparam int          CFG_IDX_BITS  = 1;
    localparam int          CFG_DATA_BITS = 16;
    localparam logic [0:0]  REG_GRID_SIZE = 1'd0;
    localparam logic [0:0]  REG_SEA_MARK  = 1'd1;

    // Field widths
    localparam int GRID_FIELD_BITS = 12;
    localparam int SEA_BITS        = 16;
    localparam int DIR_BITS        = 4;

    // Direction codes: 0..7 run east, south-east, ... north-east; none is 8
    localparam logic [DIR_BITS-1:0] DIR_NONE = 4'd8;

    // Drop weights: orthogonal drop * 1414 against diagonal drop * 1000
    localparam int               WEIGHT_BITS  = 11;
    localparam logic [10:0]      ORTHO_WEIGHT = 11'd1414;
    localparam logic [10:0]      DIAG_WEIGHT  = 11'd1000;

    // Window tap (row * 3 + column) of the neighbour in each direction
    localparam logic [3:0] DIR_TAP [8] = '{4'd5, 4'd8, 4'd7, 4'd6, 4'd3, 4'd0, 4'd1, 4'd2};

    // Position of a result cell inside the grid
    typedef struct packed {
        logic north;   // row above is on the grid
        logic south;   // row below is on the grid
        logic west;    // column to the west is on the grid
        logic east;    // column to the east is on the grid
        logic last;    // last cell of the frame
    } t_cell_info;

endpackage

@@ src/d8fd_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// D8 flow direction window builder
// Holds two sample rows in a column-addressed line memory, tracks the raster
// position and assembles the 3x3 neighbourhood of each result cell.
// ----------------------------------------------------------------------------
module d8fd_window #(
    parameter int MAX_WIDTH   = 2048,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]     i_grid_size,
    input  logic                               i_restart,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_action,
    input  logic [SAMPLE_BITS-1:0]             i_height,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [SAMPLE_BITS-1:0]             o_window [9],
    output d8fd_pkg::t_cell_info               o_info
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int GW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_WIDTH + 2);
    localparam int SB = SAMPLE_BITS;

    // Line memory: per column {sample two rows up, sample one row up}
    logic [2*SB-1:0] mem [MAX_WIDTH];
    logic [2*SB-1:0] r_rd;

    logic [CW-1:0] r_in_col,  n_in_col;
    logic [RW-1:0] r_in_row,  n_in_row;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [CW-1:0] r_out_row, n_out_row;

    logic                 r_s1_valid;
    logic                 r_wr_pend;
    logic                 r_s1_emit;
    d8fd_pkg::t_cell_info r_s1_info;
    logic [SB-1:0]        r_s1_h;
    logic [CW-1:0]        r_s1_col;

    logic [SB-1:0] r_col1 [3];
    logic [SB-1:0] r_col2 [3];

    logic                 accept;
    logic                 s1_leave;
    logic                 emit;
    logic [GW-1:0]        g_m1;
    d8fd_pkg::t_cell_info info;
    logic [SB-1:0]        h;

    // Handshake of the first stage
    assign s1_leave = r_s1_valid && (i_ready || !r_s1_emit);
    assign accept   = i_valid && (!r_s1_valid || s1_leave);
    assign o_stall  = r_s1_valid && !s1_leave;
    assign o_valid  = r_s1_valid && r_s1_emit;

    // Decode the raster position of the incoming request
    assign g_m1 = i_grid_size - GW'(1);
    assign emit = (r_in_row >= RW'(2)) || ((r_in_row == RW'(1)) && (r_in_col != '0));
    assign h    = i_action ? '0 : i_height;

    always_comb begin
        info.north = (r_out_row != '0);
        info.south = (GW'(r_out_row) != g_m1);
        info.west  = (r_out_col != '0);
        info.east  = (GW'(r_out_col) != g_m1);
        info.last  = emit && !info.south && !info.east;
    end

    // Advance the input and result positions
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (i_restart) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (accept) begin
            if (info.last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else begin
                if (GW'(r_in_col) == g_m1) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + RW'(1);
                end else begin
                    n_in_col = r_in_col + CW'(1);
                end
                if (emit) begin
                    if (GW'(r_out_col) == g_m1) begin
                        n_out_col = '0;
                        n_out_row = r_out_row + CW'(1);
                    end else begin
                        n_out_col = r_out_col + CW'(1);
                    end
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_s1_valid <= 1'b0;
            r_wr_pend  <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_wr_pend <= accept;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_leave) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Read the column on acceptance, write it back in the following cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= mem[r_in_col];
        end
        if (r_wr_pend) begin
            mem[r_s1_col] <= {r_rd[SB-1:0], r_s1_h};
        end
    end

    // Hold the accepted request in the first stage
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_emit <= emit;
            r_s1_info <= info;
            r_s1_h    <= h;
            r_s1_col  <= r_in_col;
        end
    end

    // Shift the column triplets as each request leaves
    always_ff @(posedge i_clk) begin
        if (s1_leave) begin
            r_col2    <= r_col1;
            r_col1[0] <= r_rd[2*SB-1:SB];
            r_col1[1] <= r_rd[SB-1:0];
            r_col1[2] <= r_s1_h;
        end
    end

    // Assemble the neighbourhood, row above first
    assign o_window[0] = r_col2[0];
    assign o_window[1] = r_col1[0];
    assign o_window[2] = r_rd[2*SB-1:SB];
    assign o_window[3] = r_col2[1];
    assign o_window[4] = r_col1[1];
    assign o_window[5] = r_rd[SB-1:0];
    assign o_window[6] = r_col2[2];
    assign o_window[7] = r_col1[2];
    assign o_window[8] = r_s1_h;
    assign o_info      = r_s1_info;

endmodule

@@ src/d8_flow_direction_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// D8 flow direction core
// Streams a square heightmap in raster order and gives each cell's steepest
// descent direction, weighting diagonal drops by 1/1.414.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle unless stalled; the line memory is read and
//   written once per request on separate cycles; requests follow back to back.
// Path: the request completing a cell's window, grid_size+1 requests after its
//   sample, passes the window, drop, slope, pick and output registers.
// Reset: grid_size = min(2048, MAX_WIDTH), sea mark 0, positions cleared;
//   the line memory is not cleared.
module d8_flow_direction_core #(
    parameter int MAX_WIDTH   = 2048,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_action,
    input  logic [SAMPLE_BITS-1:0]               i_height,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [d8fd_pkg::DIR_BITS-1:0]        o_flow_dir,
    output logic                                 o_below_sea,
    output logic                                 o_frame_end,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [d8fd_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [d8fd_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam int GW         = $clog2(MAX_WIDTH + 1);
    localparam int SB         = SAMPLE_BITS;
    localparam int SW         = SAMPLE_BITS + d8fd_pkg::WEIGHT_BITS;
    localparam int CLAMP_BITS = (GW > d8fd_pkg::GRID_FIELD_BITS) ? GW
                                                                 : d8fd_pkg::GRID_FIELD_BITS;
    localparam int CMP_BITS   = (SB > d8fd_pkg::SEA_BITS) ? SB : d8fd_pkg::SEA_BITS;
    localparam int RESET_GRID = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;

    // ---------------- configuration ----------------
    logic [GW-1:0]                   r_grid_size;
    logic [d8fd_pkg::SEA_BITS-1:0]   r_sea_mark;
    logic [CLAMP_BITS-1:0]           grid_raw;
    logic [GW-1:0]                   grid_clamped;
    logic                            cfg_write;
    logic                            restart;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign restart     = cfg_write && (i_cfg_index == d8fd_pkg::REG_GRID_SIZE);
    assign grid_raw    = CLAMP_BITS'(i_cfg_data[d8fd_pkg::GRID_FIELD_BITS-1:0]);

    // Clamp the grid size into the supported range
    always_comb begin
        if (grid_raw < CLAMP_BITS'(2)) begin
            grid_clamped = GW'(2);
        end else if (grid_raw > CLAMP_BITS'(MAX_WIDTH)) begin
            grid_clamped = GW'(MAX_WIDTH);
        end else begin
            grid_clamped = GW'(grid_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= GW'(RESET_GRID);
            r_sea_mark  <= '0;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                d8fd_pkg::REG_GRID_SIZE: r_grid_size <= grid_clamped;
                d8fd_pkg::REG_SEA_MARK:  r_sea_mark  <= i_cfg_data[d8fd_pkg::SEA_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- window ----------------
    logic                 win_valid;
    logic                 win_ready;
    logic [SB-1:0]        win [9];
    d8fd_pkg::t_cell_info win_info;

    d8fd_window #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grid_size (r_grid_size),
        .i_restart   (restart),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_action    (i_action),
        .i_height    (i_height),
        .o_valid     (win_valid),
        .i_ready     (win_ready),
        .o_window    (win),
        .o_info      (win_info)
    );

    // ---------------- pipeline handshake ----------------
    logic r_v2, r_v3, r_v4, r_v5, r_out_valid;
    logic rdy2, rdy3, rdy4, rdy5, rdy_out;

    assign rdy_out   = !r_out_valid || !i_stall;
    assign rdy5      = !r_v5 || rdy_out;
    assign rdy4      = !r_v4 || rdy5;
    assign rdy3      = !r_v3 || rdy4;
    assign rdy2      = !r_v2 || rdy3;
    assign win_ready = rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rdy2) begin
                r_v2 <= win_valid;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (rdy5) begin
                r_v5 <= r_v4;
            end
            if (rdy_out) begin
                r_out_valid <= r_v5;
            end
        end
    end

    // ---------------- drops ----------------
    logic [SB-1:0] center;
    logic          below;
    logic [7:0]    on_grid;
    logic [SB-1:0] drop [8];

    assign center = win[4];
    assign below  = CMP_BITS'(center) <= CMP_BITS'(r_sea_mark);

    always_comb begin
        on_grid[0] = win_info.east;
        on_grid[1] = win_info.east && win_info.south;
        on_grid[2] = win_info.south;
        on_grid[3] = win_info.south && win_info.west;
        on_grid[4] = win_info.west;
        on_grid[5] = win_info.north && win_info.west;
        on_grid[6] = win_info.north;
        on_grid[7] = win_info.north && win_info.east;
    end

    // Drop to each strictly lower on-grid neighbour, zero otherwise and for cells at or below the sea mark
    always_comb begin
        logic [SB-1:0] nh;
        for (int d = 0; d < 8; d++) begin
            nh = win[d8fd_pkg::DIR_TAP[d]];
            if (on_grid[d] && !below && (nh < center)) begin
                drop[d] = center - nh;
            end else begin
                drop[d] = '0;
            end
        end
    end

    logic [SB-1:0] r_s2_drop [8];
    logic          r_s2_below, r_s2_last;

    always_ff @(posedge i_clk) begin
        if (rdy2 && win_valid) begin
            r_s2_drop  <= drop;
            r_s2_below <= below;
            r_s2_last  <= win_info.last;
        end
    end

    // ---------------- weighted slopes ----------------
    logic [SW-1:0] r_s3_slope [8];
    logic          r_s3_below, r_s3_last;

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_v2) begin
            for (int d = 0; d < 8; d++) begin
                if (d % 2 == 1) begin
                    r_s3_slope[d] <= SW'(r_s2_drop[d]) * SW'(d8fd_pkg::DIAG_WEIGHT);
                end else begin
                    r_s3_slope[d] <= SW'(r_s2_drop[d]) * SW'(d8fd_pkg::ORTHO_WEIGHT);
                end
            end
            r_s3_below <= r_s2_below;
            r_s3_last  <= r_s2_last;
        end
    end

    // ---------------- steepest pick, lower direction wins ties ----------------
    logic [SW-1:0] r_s4_slope [4];
    logic [2:0]    r_s4_dir   [4];
    logic          r_s4_below, r_s4_last;

    always_ff @(posedge i_clk) begin
        if (rdy4 && r_v3) begin
            for (int k = 0; k < 4; k++) begin
                if (r_s3_slope[2*k+1] > r_s3_slope[2*k]) begin
                    r_s4_slope[k] <= r_s3_slope[2*k+1];
                    r_s4_dir[k]   <= 3'(2*k+1);
                end else begin
                    r_s4_slope[k] <= r_s3_slope[2*k];
                    r_s4_dir[k]   <= 3'(2*k);
                end
            end
            r_s4_below <= r_s3_below;
            r_s4_last  <= r_s3_last;
        end
    end

    logic [SW-1:0] r_s5_slope [2];
    logic [2:0]    r_s5_dir   [2];
    logic          r_s5_below, r_s5_last;

    always_ff @(posedge i_clk) begin
        if (rdy5 && r_v4) begin
            for (int k = 0; k < 2; k++) begin
                if (r_s4_slope[2*k+1] > r_s4_slope[2*k]) begin
                    r_s5_slope[k] <= r_s4_slope[2*k+1];
                    r_s5_dir[k]   <= r_s4_dir[2*k+1];
                end else begin
                    r_s5_slope[k] <= r_s4_slope[2*k];
                    r_s5_dir[k]   <= r_s4_dir[2*k];
                end
            end
            r_s5_below <= r_s4_below;
            r_s5_last  <= r_s4_last;
        end
    end

    // ---------------- output register ----------------
    logic [SW-1:0] best_slope;
    logic [2:0]    best_dir;

    always_comb begin
        if (r_s5_slope[1] > r_s5_slope[0]) begin
            best_slope = r_s5_slope[1];
            best_dir   = r_s5_dir[1];
        end else begin
            best_slope = r_s5_slope[0];
            best_dir   = r_s5_dir[0];
        end
    end

    logic [d8fd_pkg::DIR_BITS-1:0] r_flow_dir;
    logic                          r_below_sea, r_frame_end;

    always_ff @(posedge i_clk) begin
        if (rdy_out && r_v5) begin
            r_flow_dir  <= (best_slope == '0) ? d8fd_pkg::DIR_NONE
                                              : d8fd_pkg::DIR_BITS'(best_dir);
            r_below_sea <= r_s5_below;
            r_frame_end <= r_s5_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_flow_dir  = r_flow_dir;
    assign o_below_sea = r_below_sea;
    assign o_frame_end = r_frame_end;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// D8 flow direction core testbench
// Streams heightmap frames of many sizes and sea levels into the core while
// both sides idle at random. Each cell's drain direction is predicted, and
// every result is compared field by field, in arrival order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RING_DEPTH        = 4100;
    localparam int GRID_CEILING      = 2048;
    localparam int ORTHO_SCALE       = 1414;
    localparam int DIAG_SCALE        = 1000;
    localparam int SETTLE_CYCLES     = 16;
    localparam int TAIL_CYCLES       = 24;
    localparam int RX_HOLD_CYCLES    = 300;
    localparam int RANDOM_REQUESTS   = 1200;
    localparam int OVERSIZE_REQUESTS = 40;
    localparam int CYCLE_LIMIT       = 800000;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_DRAIN  = 1'b1;

    // Neighbour step per direction code, east first and then clockwise
    localparam int COL_STEP [8] = '{1, 1, 0, -1, -1, -1, 0, 1};
    localparam int ROW_STEP [8] = '{0, 1, 1, 1, 0, -1, -1, -1};

    // Idle limits for one frame; zero gives a stretch with no idling
    localparam int GAP_CHOICE [4] = '{0, 3, 16, 16};

    typedef enum int {TERRAIN_ROUGH, TERRAIN_FLAT, TERRAIN_CLIFF, TERRAIN_LOW} t_terrain;

    typedef struct {
        logic [d8fd_pkg::DIR_BITS-1:0] dir;
        logic                          below;
        logic                          frame_end;
    } t_cell_result;

    // Predict each cell's drain result and hold it until the core gives it
    class t_drain_scoreboard;
        logic [15:0]  heights [RING_DEPTH];
        int           grid;
        int           sea;
        int           in_col;
        int           in_row;
        int           out_col;
        int           out_row;
        int           wr_pos;
        int           failures;
        t_cell_result due_cells [$];

        function new();
            grid     = GRID_CEILING;
            sea      = 0;
            failures = 0;
            restart();
        endfunction

        function void restart();
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
            wr_pos  = 0;
        endfunction

        function void apply_reg(logic [d8fd_pkg::CFG_IDX_BITS-1:0] idx,
                                logic [d8fd_pkg::CFG_DATA_BITS-1:0] data);
            if (idx == d8fd_pkg::REG_GRID_SIZE) begin
                grid = int'(data[d8fd_pkg::GRID_FIELD_BITS-1:0]);
                if (grid < 2) grid = 2;
                if (grid > GRID_CEILING) grid = GRID_CEILING;
                restart();
            end else if (idx == d8fd_pkg::REG_SEA_MARK) begin
                sea = int'(data[d8fd_pkg::SEA_BITS-1:0]);
            end
        endfunction

        // The newest request holds the south-east neighbour of the result cell
        function logic [15:0] tap(int dr, int dc);
            int back;
            back = grid + 1 - dr * grid - dc;
            return heights[(wr_pos + RING_DEPTH - back) % RING_DEPTH];
        endfunction

        function bit on_grid(int dr, int dc);
            int r;
            int c;
            r = out_row + dr;
            c = out_col + dc;
            return r >= 0 && r < grid && c >= 0 && c < grid;
        endfunction

        function int outstanding();
            return due_cells.size();
        endfunction

        function void note_request(logic act, logic [15:0] h);
            t_cell_result res;
            logic [15:0]  centre;
            logic [15:0]  nb;
            longint       slope;
            longint       best;
            bit           emit;
            bit           last;
            int           dr;
            int           dc;
            emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
            last = 1'b0;
            // A drain step takes a cell position with zero height
            heights[wr_pos] = (act == ACT_DRAIN) ? 16'd0 : h;
            if (emit) begin
                centre    = tap(0, 0);
                res.dir   = d8fd_pkg::DIR_NONE;
                res.below = (centre <= sea);
                best      = 0;
                if (!res.below) begin
                    // Steepest strictly lower neighbour; ties keep the first direction
                    for (int d = 0; d < 8; d++) begin
                        dr = ROW_STEP[d];
                        dc = COL_STEP[d];
                        if (on_grid(dr, dc)) begin
                            nb = tap(dr, dc);
                            if (nb < centre) begin
                                slope = longint'(centre - nb) *
                                        ((dr != 0 && dc != 0) ? DIAG_SCALE : ORTHO_SCALE);
                                if (slope > best) begin
                                    best    = slope;
                                    res.dir = d[d8fd_pkg::DIR_BITS-1:0];
                                end
                            end
                        end
                    end
                end
                last          = (out_row + 1 >= grid) && (out_col + 1 >= grid);
                res.frame_end = last;
                due_cells.insert(due_cells.size(), res);
            end
            if (last) begin
                restart();
                return;
            end
            // Advance the stream and result positions
            in_col++;
            if (in_col >= grid) begin
                in_col = 0;
                in_row++;
            end
            wr_pos = (wr_pos + 1) % RING_DEPTH;
            if (emit) begin
                out_col++;
                if (out_col >= grid) begin
                    out_col = 0;
                    out_row++;
                end
            end
        endfunction

        function void check_result(logic [d8fd_pkg::DIR_BITS-1:0] dir, logic below,
                                   logic frame_end);
            t_cell_result want;
            if (due_cells.size() == 0) begin
                $display("%0t: unexpected result, expected none, got flow_dir %0d below_sea %0b frame_end %0b",
                         $time, dir, below, frame_end);
                failures++;
                return;
            end
            want = due_cells.pop_front();
            if (dir !== want.dir) begin
                $display("%0t: flow_dir mismatch, expected %0d, got %0d", $time, want.dir, dir);
                failures++;
            end
            if (below !== want.below) begin
                $display("%0t: below_sea mismatch, expected %0b, got %0b", $time, want.below, below);
                failures++;
            end
            if (frame_end !== want.frame_end) begin
                $display("%0t: frame_end mismatch, expected %0b, got %0b",
                         $time, want.frame_end, frame_end);
                failures++;
            end
        endfunction
    endclass

    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_valid     = 1'b0;
    logic                               o_stall;
    logic                               i_action    = ACT_SAMPLE;
    logic [15:0]                        i_height    = 16'd0;
    logic                               o_valid;
    logic                               i_stall     = 1'b0;
    logic [d8fd_pkg::DIR_BITS-1:0]      o_flow_dir;
    logic                               o_below_sea;
    logic                               o_frame_end;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [d8fd_pkg::CFG_IDX_BITS-1:0]  i_cfg_index = d8fd_pkg::REG_GRID_SIZE;
    logic [d8fd_pkg::CFG_DATA_BITS-1:0] i_cfg_data  = '0;

    t_drain_scoreboard sb = new();

    int tx_gap_max  = 0;
    int rx_gap_max  = 0;
    int rx_wait     = 0;
    int cycles      = 0;
    int random_sent = 0;
    bit rx_hold_go  = 1'b0;
    bit rx_holding  = 1'b0;

    d8_flow_direction_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_action    (i_action),
        .i_height    (i_height),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_flow_dir  (o_flow_dir),
        .o_below_sea (o_below_sea),
        .o_frame_end (o_frame_end),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // Check each accepted result, then draw the stall before the next one
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            sb.check_result(o_flow_dir, o_below_sea, o_frame_end);
            rx_wait = $urandom_range(0, rx_gap_max);
        end
    end

    // Long hold-off of the result side, counted here
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_go) begin
                rx_hold_go = 1'b0;
                rx_holding = 1'b1;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_holding = 1'b0;
            end
        end
    end

    // Drive the result-side stall
    always @(negedge i_clk) begin
        if (rx_holding) begin
            i_stall = 1'b1;
        end else if (rx_wait > 0) begin
            i_stall = 1'b1;
            rx_wait--;
        end else begin
            i_stall = 1'b0;
        end
    end

    function automatic logic [15:0] draw_height(t_terrain terrain);
        case (terrain)
            TERRAIN_ROUGH: return 16'($urandom);
            // Near-flat ground gives flats, pits and equal drops
            TERRAIN_FLAT:  return 16'(1000 + $urandom_range(0, 3));
            TERRAIN_CLIFF: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default:       return 16'($urandom_range(0, 600));
        endcase
    endfunction

    // Offer one request after a random gap and hold it until accepted
    task automatic push_request(logic act, logic [15:0] h);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_action = act;
        i_height = h;
        i_valid  = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(act, h);
    endtask

    // Drop the request line and wait until every predicted result has come
    task automatic pause_sender();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // Write a register once the core is idle
    task automatic write_reg(logic [d8fd_pkg::CFG_IDX_BITS-1:0] idx,
                             logic [d8fd_pkg::CFG_DATA_BITS-1:0] data);
        pause_sender();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        int       g;
        int       r;
        int       n;
        int       total;
        int       frame_no;
        t_terrain terrain;
        logic [d8fd_pkg::CFG_DATA_BITS-1:0] grid_word;
        logic [d8fd_pkg::CFG_DATA_BITS-1:0] sea_word;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // 2x2 frame from a grid size below the minimum: tie, drain in the
        // frame, sample and drain steps during the flush
        tx_gap_max = 2;
        rx_gap_max = 2;
        write_reg(d8fd_pkg::REG_GRID_SIZE, 16'd1);
        write_reg(d8fd_pkg::REG_SEA_MARK, 16'd0);
        push_request(ACT_SAMPLE, 16'hFFFF);
        push_request(ACT_SAMPLE, 16'h0000);
        push_request(ACT_DRAIN,  16'hFFFF);
        push_request(ACT_SAMPLE, 16'hFFFF);
        push_request(ACT_SAMPLE, 16'hFFFF);
        push_request(ACT_DRAIN,  16'h0000);
        push_request(ACT_SAMPLE, 16'h0000);

        // 3x3 frame around sea level with a peak in the middle
        write_reg(d8fd_pkg::REG_GRID_SIZE, 16'd3);
        write_reg(d8fd_pkg::REG_SEA_MARK, 16'd100);
        push_request(ACT_SAMPLE, 16'd500);
        push_request(ACT_SAMPLE, 16'd500);
        push_request(ACT_SAMPLE, 16'd100);
        push_request(ACT_SAMPLE, 16'd500);
        push_request(ACT_SAMPLE, 16'hFFFF);
        push_request(ACT_SAMPLE, 16'd500);
        push_request(ACT_DRAIN,  16'h1234);
        push_request(ACT_SAMPLE, 16'd101);
        push_request(ACT_SAMPLE, 16'd0);
        push_request(ACT_SAMPLE, 16'hFFFF);
        push_request(ACT_DRAIN,  16'h0000);
        push_request(ACT_SAMPLE, 16'h0000);
        push_request(ACT_DRAIN,  16'hFFFF);

        // Oversized grid counts as the widest: start a frame, then cut it
        // short with the next grid write
        tx_gap_max = 3;
        rx_gap_max = 3;
        write_reg(d8fd_pkg::REG_GRID_SIZE, 16'hFFFF);
        write_reg(d8fd_pkg::REG_SEA_MARK, 16'($urandom_range(0, 30000)));
        for (int k = 0; k < OVERSIZE_REQUESTS; k++) begin
            push_request($urandom_range(0, 31) == 0 ? ACT_DRAIN : ACT_SAMPLE,
                         draw_height(TERRAIN_ROUGH));
        end

        // Random frames, some cut short
        frame_no = 0;
        while (random_sent < RANDOM_REQUESTS) begin
            r = $urandom_range(0, 9);
            if (frame_no == 2) g = 10;
            else if (r < 6) g = $urandom_range(2, 6);
            else if (r < 9) g = $urandom_range(7, 14);
            else g = $urandom_range(15, 24);
            grid_word = 16'(g);
            if (g == 2 && $urandom_range(0, 1) == 1) grid_word = 16'($urandom_range(0, 1));
            case (frame_no % 4)
                0:       sea_word = 16'h0000;
                1:       sea_word = 16'hFFFF;
                2:       sea_word = 16'($urandom);
                default: sea_word = 16'($urandom_range(0, 600));
            endcase
            write_reg(d8fd_pkg::REG_GRID_SIZE, grid_word);
            write_reg(d8fd_pkg::REG_SEA_MARK, sea_word);
            terrain    = t_terrain'($urandom_range(0, 3));
            tx_gap_max = GAP_CHOICE[$urandom_range(0, 3)];
            rx_gap_max = GAP_CHOICE[$urandom_range(0, 3)];
            // Hold the result side off while requests keep coming, to fill the core
            if (frame_no == 2) begin
                tx_gap_max = 0;
                rx_hold_go = 1'b1;
            end
            total = g * g + g + 1;
            n = total;
            if (frame_no > 3 && $urandom_range(0, 7) == 0) n = $urandom_range(1, total - 1);
            for (int k = 0; k < n; k++) begin
                if (frame_no == 3 && k == g * g / 2) pause_sender();
                if (k < g * g) begin
                    push_request($urandom_range(0, 15) == 0 ? ACT_DRAIN : ACT_SAMPLE,
                                 draw_height(terrain));
                end else begin
                    push_request($urandom_range(0, 1) ? ACT_DRAIN : ACT_SAMPLE, 16'($urandom));
                end
            end
            random_sent += n;
            frame_no++;
        end

        pause_sender();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.failures == 0 && sb.outstanding() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

@@ d8_flow_direction_core.f @@
src/d8fd_pkg.sv
src/d8fd_window.sv
src/d8_flow_direction_core.sv
sim/testbench.sv
